/* src/lss_pkg.sv */
// Shared types and constants for the search-capable LIFO stack.
// Used by the controller, the datapath and the top level; no dependencies.
package lss_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int DIST_W = 6;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_PEEK   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_code_type;

   typedef struct packed {
      op_type                    req_type;
      logic signed [WORD_W-1:0]  data_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  data_out;
      logic [DIST_W-1:0]         distance;
      logic                      is_empty;
      status_code_type           status;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic            latch_req;
      logic            push_wr;
      logic            top_rd;
      logic            pop_dec;
      logic            scan_start;
      logic            scan_step;
      logic            res_set;
      status_code_type res_status;
      logic            res_take_data;
      logic            res_take_dist;
      logic            load_rsp;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   scan_hit;
      logic   scan_last;
      logic   rsp_free;
   } dp_stat_type;

endpackage

/* src/lss_dp.sv */
// Datapath of the LIFO stack: request latch, entry store, count, scan
// index and result registers. Depends on lss_pkg.
module lss_dp import lss_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  ctl_cmd_type     cmd,
   output dp_stat_type     stat,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data
);

   logic [WORD_W-1:0] mem [DEPTH];

   req_payload_type   req_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  k_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [WORD_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr_in;
   logic [CNT_W-1:0]  top_cnt;
   logic [CNT_W-1:0]  dist_full;

   logic signed [WORD_W-1:0] res_data_ff;
   logic [DIST_W-1:0]        res_dist_ff;
   status_code_type          res_status_ff;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;

   assign top_cnt   = count_ff - CNT_W'(1);
   assign dist_full = top_cnt - CNT_W'(rd_idx_ff);

   always_comb begin
      if (cmd.top_rd) begin
         rd_addr_in = top_cnt[IDX_W-1:0];
      end else if (cmd.scan_start) begin
         rd_addr_in = '0;
      end else begin
         rd_addr_in = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         mem[count_ff[IDX_W-1:0]] <= req_ff.data_in;
      end
      if (cmd.top_rd || cmd.scan_start || cmd.scan_step) begin
         rd_data_ff <= mem[rd_addr_in];
         rd_idx_ff  <= rd_addr_in;
         k_ff       <= rd_addr_in + IDX_W'(1);
      end
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_data_ff   <= cmd.res_take_data ? rd_data_ff : '0;
         res_dist_ff   <= cmd.res_take_dist ? DIST_W'(dist_full) : '0;
      end
      if (cmd.load_rsp) begin
         rsp_ff.data_out <= res_data_ff;
         rsp_ff.distance <= res_dist_ff;
         rsp_ff.is_empty <= (count_ff == '0);
         rsp_ff.status   <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.push_wr) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.pop_dec) begin
            count_ff <= top_cnt;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.op        = req_ff.req_type;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.scan_hit  = (rd_data_ff == req_ff.data_in);
   assign stat.scan_last = (CNT_W'(rd_idx_ff) == top_cnt);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/lss_ctrl.sv */
// Controller of the LIFO stack: sequences decode, top read and search scan.
// Drives datapath commands from its status. Depends on lss_pkg.
module lss_ctrl import lss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_PUSH: begin
                  cmd.res_set = 1'b1;
                  if (stat.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.push_wr    = 1'b1;
                     cmd.res_status = ST_OK;
                  end
                  state_in = S_FINISH;
               end
               OP_POP, OP_PEEK: begin
                  if (stat.empty) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_EMPTY;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.top_rd = 1'b1;
                     state_in   = S_READ;
                  end
               end
               OP_SEARCH: begin
                  if (stat.empty) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_NOTFOUND;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
            endcase
         end
         S_READ: begin
            cmd.res_set       = 1'b1;
            cmd.res_status    = ST_OK;
            cmd.res_take_data = 1'b1;
            cmd.pop_dec       = (stat.op == OP_POP);
            state_in          = S_FINISH;
         end
         S_SCAN: begin
            // bottom-up walk: the first hit is the deepest match
            if (stat.scan_hit) begin
               cmd.res_set       = 1'b1;
               cmd.res_status    = ST_OK;
               cmd.res_take_dist = 1'b1;
               state_in          = S_FINISH;
            end else if (stat.scan_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NOTFOUND;
               state_in       = S_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_FINISH: begin
            // hold the result until the output register is free
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/lifo_stack_with_search.sv */
// Top level of the search-capable LIFO stack: controller plus datapath.
// Depends on lss_pkg, lss_ctrl and lss_dp.
//
//   channel   direction  ports                          payload
//   request   in         req_valid req_ready req_data   req_payload_type
//   result    out        rsp_valid rsp_ready rsp_data   rsp_payload_type
//
// A push is handled in S_DECODE and a pop or peek reads the top entry in
// S_READ; a search walks up to DEPTH entries from the bottom, one entry a
// cycle through the single read port of the entry store, and stops at the
// first hit or at the top entry. The next request is accepted in the cycle
// after the result is loaded into the output register.
// A new request is accepted once the previous one has been placed in the
// output register, so one result may wait while the next request runs.
// Reset empties the stack at once; store contents are not cleared.
// A stalled result holds the finished request in its final state.
module lifo_stack_with_search import lss_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   lss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lss_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while controller busy");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |-> !rsp_data.is_empty)
      else $error("refused push reported an empty stack");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EMPTY) |->
      (rsp_data.is_empty && rsp_data.data_out == '0))
      else $error("empty status with data or nonempty stack");

   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push_wr && (cmd.pop_dec || cmd.top_rd || cmd.scan_step)))
      else $error("store write overlaps a read command");
`endif

endmodule

/* sim/lss_tb_pkg.sv */
// Scoreboard for the search-capable LIFO stack testbench: tracks the stack
// contents and checks each result against the oldest prediction.
// Depends on lss_pkg.
package lss_tb_pkg;
   import lss_pkg::*;

   class stack_tracker;
      logic [WORD_W-1:0] words [DEPTH];
      int unsigned       held;
      rsp_payload_type   expected_rsp [$];
      int unsigned       failures;

      function new();
         held = 0;
         failures = 0;
      endfunction

      function int unsigned level();
         return held;
      endfunction

      function logic [WORD_W-1:0] word_at(int unsigned idx);
         return words[idx];
      endfunction

      function int unsigned outstanding();
         return expected_rsp.size();
      endfunction

      // Apply one accepted request to the tracked stack and queue its result.
      function void note_request(req_payload_type req);
         rsp_payload_type e;
         bit              found;
         e = '0;
         e.status = ST_OK;
         found = 1'b0;
         case (req.req_type)
            OP_PUSH: begin
               if (held == DEPTH) begin
                  e.status = ST_FULL;
               end else begin
                  words[held] = req.data_in;
                  held++;
               end
            end
            OP_POP: begin
               if (held == 0) begin
                  e.status = ST_EMPTY;
               end else begin
                  held--;
                  e.data_out = words[held];
               end
            end
            OP_PEEK: begin
               if (held == 0)
                  e.status = ST_EMPTY;
               else
                  e.data_out = words[held - 1];
            end
            default: begin
               e.status = ST_NOTFOUND;
               // scan from the bottom; the deepest match wins
               for (int unsigned k = 0; k < held; k++) begin
                  if (!found && words[k] == req.data_in) begin
                     found = 1'b1;
                     e.distance = DIST_W'(held - 1 - k);
                     e.status = ST_OK;
                  end
               end
            end
         endcase
         e.is_empty = (held == 0);
         expected_rsp.push_back(e);
      endfunction

      function void check_result(rsp_payload_type act);
         rsp_payload_type e;
         if (expected_rsp.size() == 0) begin
            $error("unexpected result: data_out %0d status %0d", act.data_out, act.status);
            failures++;
            return;
         end
         e = expected_rsp.pop_front();
         if (act.data_out !== e.data_out) begin
            $error("data_out: expected %0d, actual %0d", e.data_out, act.data_out);
            failures++;
         end
         if (act.distance !== e.distance) begin
            $error("distance: expected %0d, actual %0d", e.distance, act.distance);
            failures++;
         end
         if (act.is_empty !== e.is_empty) begin
            $error("is_empty: expected %0b, actual %0b", e.is_empty, act.is_empty);
            failures++;
         end
         if (act.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, act.status);
            failures++;
         end
      endfunction
   endclass

endpackage

/* sim/tb.sv */
// Top-level testbench for lifo_stack_with_search: directed and random
// push/pop/peek/search traffic with random idling on both channels.
// Depends on lss_pkg, lss_tb_pkg and the stack RTL.
module tb;
   import lss_pkg::*;
   import lss_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1430;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 80;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   stack_tracker    tracker = new();
   int unsigned     results_seen = 0;
   int unsigned     idle_cycles = 0;
   bit              sender_gaps = 1'b1;
   bit              held_off = 1'b0;
   logic [WORD_W-1:0] word_pool [16];

   lifo_stack_with_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         tracker.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_result(rsp_data);
         results_seen++;
      end
   end

   // End the run when no request or result moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic issue_request(op_type op, logic [WORD_W-1:0] word);
      req_payload_type p;
      p.req_type = op;
      p.data_in = word;
      while (sender_gaps && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic op_type pick_op(int trend);
      int unsigned r;
      r = $urandom_range(0, 99);
      case (trend)
         0: return (r < 70) ? OP_PUSH : (r < 80) ? OP_POP : (r < 85) ? OP_PEEK : OP_SEARCH;
         1: return (r < 15) ? OP_PUSH : (r < 70) ? OP_POP : (r < 80) ? OP_PEEK : OP_SEARCH;
         default: return op_type'(r[1:0]);
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_word(op_type op);
      int unsigned r;
      logic [WORD_W-1:0] w;
      r = $urandom_range(0, 99);
      if (op == OP_SEARCH && tracker.level() > 0 && r < 65) begin
         w = tracker.word_at($urandom_range(0, tracker.level() - 1));
         // near miss: one bit off a stored word
         if (r >= 50)
            w = w ^ (32'h1 << $urandom_range(0, WORD_W - 1));
      end else if (r < 50) begin
         w = word_pool[$urandom_range(0, 15)];
      end else begin
         w = $urandom;
      end
      return w;
   endfunction

   task automatic run_directed();
      issue_request(OP_POP, 32'h0);
      issue_request(OP_PEEK, 32'h0);
      issue_request(OP_SEARCH, 32'h0);
      issue_request(OP_PUSH, 32'h8000_0000);
      issue_request(OP_PUSH, 32'h7fff_ffff);
      issue_request(OP_PUSH, 32'h0);
      issue_request(OP_PUSH, 32'hffff_ffff);
      issue_request(OP_PUSH, 32'h7fff_ffff);
      issue_request(OP_PEEK, 32'h0);
      issue_request(OP_SEARCH, 32'h7fff_ffff);
      issue_request(OP_SEARCH, 32'h8000_0000);
      issue_request(OP_SEARCH, 32'hffff_ffff);
      issue_request(OP_SEARCH, 32'h0000_0001);
      issue_request(OP_SEARCH, 32'hffff_fffe);
      issue_request(OP_POP, 32'hffff_ffff);
      issue_request(OP_POP, 32'h0);
      issue_request(OP_PEEK, 32'h0);
      issue_request(OP_POP, 32'h0);
      issue_request(OP_POP, 32'h0);
      issue_request(OP_POP, 32'h0);
      issue_request(OP_POP, 32'h0);
   endtask

   task automatic run_random();
      int     trend;
      int     stretch;
      op_type op;
      trend = 0;
      stretch = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (stretch == 0) begin
            trend = $urandom_range(0, 2);
            stretch = $urandom_range(60, 200);
         end
         stretch--;
         sender_gaps = !(i >= 500 && i < 800);
         op = pick_op(trend);
         issue_request(op, pick_word(op));
      end
   endtask

   // Result side: random stalls, one long hold-off, a stretch with none.
   initial begin
      forever begin
         @(negedge clock);
         if (!held_off && results_seen >= 300) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held_off = 1'b1;
         end
         if (results_seen >= 500 && results_seen < 800)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(0, 99) >= 28);
      end
   end

   initial begin
      word_pool[0] = 32'h8000_0000;
      word_pool[1] = 32'h7fff_ffff;
      word_pool[2] = 32'h0;
      word_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < 16; i++)
         word_pool[i] = $urandom;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
src/lss_pkg.sv
src/lss_dp.sv
src/lss_ctrl.sv
src/lifo_stack_with_search.sv
sim/lss_tb_pkg.sv
sim/tb.sv
